// ===== design/meter_reading_average_format_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the meter reading average and format block
// Shared property wrappers, clocked on the rising edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef METER_READING_AVERAGE_FORMAT_TOP_DEFINES_SVH
`define METER_READING_AVERAGE_FORMAT_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRAF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mraf_pkg.sv =====
// ----------------------------------------------------------------------------
// Meter reading average and format package
// Configuration layout, register indexes, digit record and dot codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mraf_pkg;

	localparam int VAL_W       = 16;
	localparam int SHIFT_W     = 5;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int DIGIT_W     = 4;
	localparam int DOT_W       = 2;
	localparam int OUT_DATA_W  = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_GAIN   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_OFFSET = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_GAIN   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_OFFSET = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SCALE_SHIFT    = 3'd4;

	typedef struct packed {
		logic [VAL_W-1:0]   voltage_gain;
		logic [VAL_W-1:0]   voltage_offset;
		logic [VAL_W-1:0]   current_gain;
		logic [VAL_W-1:0]   current_offset;
		logic [SHIFT_W-1:0] scale_shift;
	} cfg_t;

	// An offset of 65531 on the current channel amounts to minus five.
	localparam cfg_t CFG_RESET = '{
		voltage_gain:   16'd1550,
		voltage_offset: 16'd0,
		current_gain:   16'd500,
		current_offset: 16'd65531,
		scale_shift:    5'd10
	};

	// Dot position codes.
	localparam logic [DOT_W-1:0] DOT_NONE       = 2'd0;
	localparam logic [DOT_W-1:0] DOT_AFTER_HIGH = 2'd1;
	localparam logic [DOT_W-1:0] DOT_AFTER_MID  = 2'd2;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

	typedef struct packed {
		logic [DIGIT_W-1:0] high;
		logic [DIGIT_W-1:0] mid;
		logic [DIGIT_W-1:0] low;
		logic [DOT_W-1:0]   dot;
	} digits_t;

endpackage

`default_nettype wire

// ===== design/mraf_window_avg.sv =====
// ----------------------------------------------------------------------------
// Moving window average
// Per-channel sample window in one memory, running totals and the average.
// ----------------------------------------------------------------------------
`default_nettype none

`include "meter_reading_average_format_top_defines.svh"

module mraf_window_avg import mraf_pkg::*; #(
	parameter int WINDOW_DEPTH = 32,
	parameter int SAMPLE_BITS  = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   in_channel,
	input  wire logic [SAMPLE_BITS-1:0] in_sample,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        out_channel,
	output logic [SAMPLE_BITS-1:0]      out_avg
);

	localparam int SLOT_W  = $clog2(WINDOW_DEPTH);
	localparam int ADDR_W  = $clog2(2 * WINDOW_DEPTH);
	localparam int TOTAL_W = SAMPLE_BITS + SLOT_W;
	// Exact division of the total by the depth through a rounded-up reciprocal.
	localparam int RECIP_K = TOTAL_W + SLOT_W;
	localparam int RECIP_W = TOTAL_W + 2;
	localparam int PROD_W  = TOTAL_W + RECIP_W;
	localparam longint unsigned RECIP_M =
		((64'd1 << RECIP_K) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_M[RECIP_W-1:0];
	localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX =
		TOTAL_W'(WINDOW_DEPTH * ((2 ** SAMPLE_BITS) - 1));

	logic [SAMPLE_BITS-1:0] window_q [2 * WINDOW_DEPTH];
	logic [SLOT_W-1:0]      slot_q [2];
	logic                   wrapped_q [2];
	logic [TOTAL_W-1:0]     total_q [2];

	logic                   valid_s1, ch_s1, old_ok_s1;
	logic [SAMPLE_BITS-1:0] rd_data_s1, smp_s1;
	logic                   valid_s2, ch_s2;
	logic [SAMPLE_BITS-1:0] avg_s2;

	logic                   free_s1, free_s2, accept, move_s1;
	logic [SLOT_W-1:0]      slot_cur;
	logic [ADDR_W-1:0]      addr;
	logic [SAMPLE_BITS-1:0] old_smp;
	logic [TOTAL_W-1:0]     total_cur, total_next;
	logic [PROD_W-1:0]      prod;

	assign free_s2  = !valid_s2 || out_ready;
	assign free_s1  = !valid_s1 || free_s2;
	assign move_s1  = valid_s1 && free_s2;
	assign in_ready = free_s1;
	assign accept   = in_valid && free_s1;

	assign slot_cur = slot_q[in_channel];
	assign addr     = in_channel ? ADDR_W'(WINDOW_DEPTH) + ADDR_W'(slot_cur)
	                             : ADDR_W'(slot_cur);

	// The oldest sample counts only once the channel's window has been filled.
	assign old_smp    = old_ok_s1 ? rd_data_s1 : '0;
	assign total_cur  = total_q[ch_s1];
	assign total_next = total_cur - TOTAL_W'(old_smp) + TOTAL_W'(smp_s1);
	assign prod       = PROD_W'(total_cur) * PROD_W'(RECIP_C);

	// Read-first: the slot's old sample comes out as the new one goes in.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_s1     <= window_q[addr];
			window_q[addr] <= in_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			slot_q[0]    <= '0;
			slot_q[1]    <= '0;
			wrapped_q[0] <= 1'b0;
			wrapped_q[1] <= 1'b0;
			total_q[0]   <= '0;
			total_q[1]   <= '0;
		end else begin
			if (free_s1) begin
				valid_s1 <= in_valid;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
			if (accept) begin
				if (slot_cur == SLOT_LAST) begin
					slot_q[in_channel]    <= '0;
					wrapped_q[in_channel] <= 1'b1;
				end else begin
					slot_q[in_channel] <= slot_cur + 1'b1;
				end
			end
			if (move_s1) begin
				total_q[ch_s1] <= total_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1     <= in_channel;
			smp_s1    <= in_sample;
			old_ok_s1 <= wrapped_q[in_channel];
		end
		if (move_s1) begin
			ch_s2  <= ch_s1;
			avg_s2 <= prod[RECIP_K +: SAMPLE_BITS];
		end
	end

	assign out_valid   = valid_s2;
	assign out_channel = ch_s2;
	assign out_avg     = avg_s2;

	`MRAF_ASSERT_NOW(a_total_bound, clk, arst_n, 1'b1,
		total_q[0] <= TOTAL_MAX && total_q[1] <= TOTAL_MAX,
		"window total beyond a full window of largest samples")
	`MRAF_ASSERT_NEXT(a_wrap_sticky, clk, arst_n, wrapped_q[0] && wrapped_q[1],
		wrapped_q[0] && wrapped_q[1], "window fill flag cleared after wrap")

endmodule

`default_nettype wire

// ===== design/mraf_calibrate.sv =====
// ----------------------------------------------------------------------------
// Calibration
// Adds the channel offset, multiplies by the gain and shifts the product down.
// ----------------------------------------------------------------------------
`default_nettype none

module mraf_calibrate import mraf_pkg::*; #(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cfg_t                   cfg,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   in_channel,
	input  wire logic [SAMPLE_BITS-1:0] in_avg,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        out_channel,
	output logic [VAL_W-1:0]            out_value
);

	logic                 valid_s3, ch_s3, valid_s4, ch_s4;
	logic [2*VAL_W-1:0]   prod_s3;
	logic [VAL_W-1:0]     value_s4;
	logic                 free_s3, free_s4, accept, move_s3;
	logic [VAL_W-1:0]     base, gain;

	assign free_s4  = !valid_s4 || out_ready;
	assign free_s3  = !valid_s3 || free_s4;
	assign move_s3  = valid_s3 && free_s4;
	assign in_ready = free_s3;
	assign accept   = in_valid && free_s3;

	// The offset add wraps at 16 bits.
	assign base = VAL_W'(in_avg) + (in_channel ? cfg.current_offset : cfg.voltage_offset);
	assign gain = in_channel ? cfg.current_gain : cfg.voltage_gain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (free_s3) begin
				valid_s3 <= in_valid;
			end
			if (free_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s3   <= in_channel;
			prod_s3 <= (2*VAL_W)'(base) * (2*VAL_W)'(gain);
		end
		if (move_s3) begin
			ch_s4    <= ch_s3;
			value_s4 <= VAL_W'(prod_s3 >> cfg.scale_shift);
		end
	end

	assign out_valid   = valid_s4;
	assign out_channel = ch_s4;
	assign out_value   = value_s4;

endmodule

`default_nettype wire

// ===== design/mraf_format.sv =====
// ----------------------------------------------------------------------------
// Decimal formatter
// Splits the calibrated value into three digits and a dot, holds shown digits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "meter_reading_average_format_top_defines.svh"

module mraf_format import mraf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             in_channel,
	input  wire logic [VAL_W-1:0] in_value,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  out_channel,
	output digits_t               out_digits
);

	localparam int QUOT_W = 13;
	localparam int WPROD_W = 33;
	localparam int NPROD_W = 27;
	localparam logic [VAL_W-1:0] BIG_LIMIT = 16'd1000;
	localparam logic [3:0] DEC_BASE = 4'd10;
	// Rounded-up reciprocals; each is exact over its whole input range.
	localparam logic [16:0] WIDE_DIV10_M = 17'd104858;
	localparam int          WIDE_DIV10_K = 20;
	localparam logic [13:0] DIV10_M      = 14'd13108;
	localparam int          DIV10_K      = 17;
	localparam logic [13:0] DIV100_M     = 14'd10486;
	localparam int          DIV100_K     = 20;
	localparam logic [13:0] DIV1000_M    = 14'd8389;
	localparam int          DIV1000_K    = 23;

	logic               valid_s5, ch_s5, big_s5;
	logic [VAL_W-1:0]   value_s5;
	logic [QUOT_W-1:0]  quot_s5;
	logic               valid_s6, ch_s6, big_s6;
	logic [QUOT_W-1:0]  x_s6;
	logic [9:0]         q1_s6;
	logic [6:0]         q2_s6;
	logic [2:0]         q3_s6;
	logic               out_valid_q, out_channel_q;
	digits_t            out_digits_q;
	digits_t            shown_q [2];

	logic               free_o, free_s6, free_s5, accept, move_s5, move_s6;
	logic               big_in;
	logic [WPROD_W-1:0] wide_prod;
	logic [QUOT_W-1:0]  x_sel;
	logic [NPROD_W-1:0] p1, p2, p3;
	logic [QUOT_W-1:0]  low_full;
	logic [9:0]         mid_full;
	logic [6:0]         high_full;
	digits_t            new_d, old_d, show_d;
	logic               keep;

	assign free_o   = !out_valid_q || out_ready;
	assign free_s6  = !valid_s6 || free_o;
	assign free_s5  = !valid_s5 || free_s6;
	assign move_s5  = valid_s5 && free_s6;
	assign move_s6  = valid_s6 && free_o;
	assign in_ready = free_s5;
	assign accept   = in_valid && free_s5;

	// Values of 1000 and above lose their last digit first.
	assign big_in    = in_value >= BIG_LIMIT;
	assign wide_prod = WPROD_W'(in_value) * WPROD_W'(WIDE_DIV10_M);

	assign x_sel = big_s5 ? quot_s5 : QUOT_W'(value_s5);
	assign p1    = NPROD_W'(x_sel) * NPROD_W'(DIV10_M);
	assign p2    = NPROD_W'(x_sel) * NPROD_W'(DIV100_M);
	assign p3    = NPROD_W'(x_sel) * NPROD_W'(DIV1000_M);

	// Each digit is a quotient less ten times the next one up; thousands drop.
	assign low_full  = x_s6 - QUOT_W'(q1_s6) * QUOT_W'(DEC_BASE);
	assign mid_full  = q1_s6 - 10'(q2_s6) * 10'(DEC_BASE);
	assign high_full = q2_s6 - 7'(q3_s6) * 7'(DEC_BASE);

	always_comb begin
		new_d.high = high_full[DIGIT_W-1:0];
		new_d.mid  = mid_full[DIGIT_W-1:0];
		new_d.low  = low_full[DIGIT_W-1:0];
		if (ch_s6) begin
			new_d.dot = big_s6 ? DOT_AFTER_HIGH : DOT_NONE;
		end else begin
			new_d.dot = big_s6 ? DOT_AFTER_MID : DOT_AFTER_HIGH;
		end
	end

	// Below the limit the last digit is held while the rest of the reading stands still.
	assign old_d  = shown_q[ch_s6];
	assign keep   = !big_s6 && new_d.high == old_d.high && new_d.mid == old_d.mid
	                && new_d.dot == old_d.dot;
	assign show_d = keep ? old_d : new_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			out_valid_q <= 1'b0;
			shown_q[0]  <= '0;
			shown_q[1]  <= '0;
		end else begin
			if (free_s5) begin
				valid_s5 <= in_valid;
			end
			if (free_s6) begin
				valid_s6 <= valid_s5;
			end
			if (free_o) begin
				out_valid_q <= valid_s6;
			end
			if (move_s6) begin
				shown_q[ch_s6] <= show_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s5    <= in_channel;
			big_s5   <= big_in;
			value_s5 <= in_value;
			quot_s5  <= wide_prod[WIDE_DIV10_K +: QUOT_W];
		end
		if (move_s5) begin
			ch_s6  <= ch_s5;
			big_s6 <= big_s5;
			x_s6   <= x_sel;
			q1_s6  <= p1[DIV10_K +: 10];
			q2_s6  <= p2[DIV100_K +: 7];
			q3_s6  <= p3[DIV1000_K +: 3];
		end
		if (move_s6) begin
			out_channel_q <= ch_s6;
			out_digits_q  <= show_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign out_digits  = out_digits_q;

	`MRAF_ASSERT_NOW(a_digit_range, clk, arst_n, out_valid_q,
		out_digits_q.high <= DIGIT_MAX && out_digits_q.mid <= DIGIT_MAX &&
		out_digits_q.low <= DIGIT_MAX, "shown digit is not decimal")
	`MRAF_ASSERT_NOW(a_current_dot, clk, arst_n, out_valid_q && out_channel_q,
		out_digits_q.dot != DOT_AFTER_MID, "current reading with voltage dot place")

endmodule

`default_nettype wire

// ===== design/meter_reading_average_format_top.sv =====
// ----------------------------------------------------------------------------
// Meter reading average and format, top level
// Moving average per channel, calibration and a three-digit decimal readout.
// ----------------------------------------------------------------------------
//
//   Port group   Direction   Carries
//   s_*          in          one ADC sample per item: tdata sample, tuser channel
//   m_*          out         one readout per item: tdata digits and dot, tuser channel
//   cfg_*        in          register writes: cfg_index selects, cfg_data holds the value
//
// One item is accepted in every clock cycle while the output side takes results.
// An accepted item passes through the window memory read and the division by the
// window depth, then through calibration, then the decimal split and the output
// register. The window memory has one port that reads the oldest sample and writes
// the new one in the cycle of accept. After reset the block is ready at once; a
// per-channel wrap flag makes unfilled window slots count as zero, so no clearing
// pass is needed.
// Each stage holds its item only while the stage after it is full and stalled, so
// input items keep flowing into empty stages while a finished result waits.
// Configuration writes are taken in every cycle and are meant for an idle block.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_reading_average_format_top import mraf_pkg::*; #(
	parameter int WINDOW_DEPTH = 32,
	parameter int SAMPLE_BITS  = 10
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// [SAMPLE_BITS-1:0] sample, upper bits padding
	input  wire logic [((SAMPLE_BITS + 7) / 8)*8-1:0] s_tdata,
	// [0] channel: 0 voltage, 1 current
	input  wire logic                                 s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// [3:0] digit_high, [7:4] digit_mid, [11:8] digit_low, [13:12] dot_place, [15:14] zero
	output logic [OUT_DATA_W-1:0]                     m_tdata,
	// [0] out_channel: 0 voltage, 1 current
	output logic                                      m_tuser,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0]               cfg_index,
	input  wire logic [CFG_DATA_W-1:0]                cfg_data
);

	cfg_t cfg_q;

	logic                   avg_valid, avg_ready, avg_channel;
	logic [SAMPLE_BITS-1:0] avg_value;
	logic                   cal_valid, cal_ready, cal_channel;
	logic [VAL_W-1:0]       cal_value;
	digits_t                out_digits;

	// Writes to an index beyond the register list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_VOLTAGE_GAIN:   cfg_q.voltage_gain   <= cfg_data;
				REG_VOLTAGE_OFFSET: cfg_q.voltage_offset <= cfg_data;
				REG_CURRENT_GAIN:   cfg_q.current_gain   <= cfg_data;
				REG_CURRENT_OFFSET: cfg_q.current_offset <= cfg_data;
				REG_SCALE_SHIFT:    cfg_q.scale_shift    <= cfg_data[SHIFT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Window average: the average is taken before the new sample joins the window.
	mraf_window_avg #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_window_avg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_channel (s_tuser),
		.in_sample  (s_tdata[SAMPLE_BITS-1:0]),
		.out_valid  (avg_valid),
		.out_ready  (avg_ready),
		.out_channel(avg_channel),
		.out_avg    (avg_value)
	);

	mraf_calibrate #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_calibrate (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (avg_valid),
		.in_ready   (avg_ready),
		.in_channel (avg_channel),
		.in_avg     (avg_value),
		.out_valid  (cal_valid),
		.out_ready  (cal_ready),
		.out_channel(cal_channel),
		.out_value  (cal_value)
	);

	// The formatter's last register is the block's output register.
	mraf_format u_format (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cal_valid),
		.in_ready   (cal_ready),
		.in_channel (cal_channel),
		.in_value   (cal_value),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_channel(m_tuser),
		.out_digits (out_digits)
	);

	assign m_tdata = OUT_DATA_W'({out_digits.dot, out_digits.low, out_digits.mid,
	                              out_digits.high});

endmodule

`default_nettype wire
